// ===== rtl/pefd_pkg.sv =====
package pefd_pkg;

   localparam int FrameBufSizeDefault = 16;
   localparam int RowsPerPageDefault  = 8;

   localparam logic [7:0] FrameStart = 8'h23;  // '#'

   localparam logic [7:0] OpPage   = 8'h50;
   localparam logic [7:0] OpNav    = 8'h51;
   localparam logic [7:0] OpRowAct = 8'h52;
   localparam logic [7:0] OpToggle = 8'h53;
   localparam logic [7:0] OpCycle  = 8'h54;
   localparam logic [7:0] OpEdit   = 8'h55;
   localparam logic [7:0] OpHome   = 8'h60;

   localparam logic [7:0] NavCfgExit = 8'h06;
   localparam logic [7:0] ByteAllOne = 8'hFF;

   localparam logic [3:0] EvCfgEnter = 4'd0;
   localparam logic [3:0] EvCfgExit  = 4'd1;
   localparam logic [3:0] EvHome     = 4'd2;
   localparam logic [3:0] EvRowAct   = 4'd7;
   localparam logic [3:0] EvToggle   = 4'd8;
   localparam logic [3:0] EvCycle    = 4'd9;
   localparam logic [3:0] EvEdit     = 4'd10;
   localparam logic [3:0] EvCommand  = 4'd11;

   // one completed frame, reduced to what the decoder looks at
   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] arg0;
      logic [7:0] arg1;
      logic       has_arg0;
      logic       has_arg1;
   } frame_desc_type;

endpackage

// ===== rtl/pefd_front.sv =====
module pefd_front
   import pefd_pkg::*;
#(
   parameter int FRAME_BUF_SIZE = FrameBufSizeDefault
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [7:0]     req_rx_byte,
   input  logic           queue_full,
   output logic           push,
   output frame_desc_type push_desc
);

   localparam int LenW = $clog2(FRAME_BUF_SIZE + 1);

   logic            in_frame_ff, in_frame_in;
   logic [LenW-1:0] len_ff, len_in;
   logic [LenW-1:0] cnt_ff, cnt_in;
   logic [7:0]      op_ff, op_in;
   logic [7:0]      p0_ff, p0_in;
   logic [7:0]      p1_ff, p1_in;
   logic            take;
   logic            len_bad;
   logic            last;

   assign req_ready = !queue_full;
   assign take      = req_valid && req_ready;
   assign len_bad   = (req_rx_byte == 8'd0) ||
                      ({1'b0, req_rx_byte} > 9'(FRAME_BUF_SIZE));
   assign last      = (cnt_ff + LenW'(1)) == len_ff;

   always_comb begin
      in_frame_in = in_frame_ff;
      len_in      = len_ff;
      cnt_in      = cnt_ff;
      op_in       = (cnt_ff == LenW'(0)) ? req_rx_byte : op_ff;
      p0_in       = (cnt_ff == LenW'(1)) ? req_rx_byte : p0_ff;
      p1_in       = (cnt_ff == LenW'(2)) ? req_rx_byte : p1_ff;
      push        = 1'b0;
      if (take) begin
         if (!in_frame_ff) begin
            if (req_rx_byte == FrameStart) begin
               in_frame_in = 1'b1;
               len_in      = '0;
               cnt_in      = '0;
            end
         end else if (len_ff == '0) begin
            if (len_bad) begin
               in_frame_in = 1'b0;
            end else begin
               len_in = LenW'(req_rx_byte);
               cnt_in = '0;
            end
         end else if (last) begin
            push        = 1'b1;
            in_frame_in = 1'b0;
            len_in      = '0;
            cnt_in      = '0;
         end else begin
            cnt_in = cnt_ff + LenW'(1);
         end
      end
   end

   assign push_desc.opcode   = op_in;
   assign push_desc.arg0     = p0_in;
   assign push_desc.arg1     = p1_in;
   assign push_desc.has_arg0 = len_ff >= LenW'(2);
   assign push_desc.has_arg1 = len_ff >= LenW'(3);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         len_ff      <= '0;
         cnt_ff      <= '0;
      end else begin
         in_frame_ff <= in_frame_in;
         len_ff      <= len_in;
         cnt_ff      <= cnt_in;
      end
      if (take && in_frame_ff && len_ff != '0) begin
         op_ff <= op_in;
         p0_ff <= p0_in;
         p1_ff <= p1_in;
      end
   end

endmodule

// ===== rtl/pefd_queue.sv =====
module pefd_queue
   import pefd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  frame_desc_type push_desc,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output frame_desc_type head_desc
);

   frame_desc_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;

   assign full       = count_ff == 2'd2;
   assign head_valid = count_ff != 2'd0;
   assign head_desc  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");
`endif

endmodule

// ===== rtl/pefd_back.sv =====
module pefd_back
   import pefd_pkg::*;
#(
   parameter int ROWS_PER_PAGE = RowsPerPageDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data,
   input  logic              head_valid,
   input  frame_desc_type    head_desc,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_event_kind,
   output logic [2:0]        rsp_row_index,
   output logic signed [1:0] rsp_step_direction,
   output logic [3:0]        rsp_command_code,
   output logic [7:0]        rsp_command_value
);

   logic [7:0]        page_id_ff;
   logic              cfg_page_ff, cfg_page_in;
   logic              valid_ff, valid_in;
   logic [3:0]        kind_ff, kind_in;
   logic [2:0]        row_ff, row_in;
   logic signed [1:0] dir_ff, dir_in;
   logic [3:0]        code_ff, code_in;
   logic [7:0]        value_ff, value_in;
   logic              hit;
   logic              row_ok;
   logic              now_cfg;

   assign pop    = head_valid && (!valid_ff || rsp_ready);
   assign row_ok = {1'b0, head_desc.arg0} < 9'(ROWS_PER_PAGE);
   assign now_cfg = head_desc.arg0 == page_id_ff;

   always_comb begin
      hit         = 1'b0;
      cfg_page_in = cfg_page_ff;
      kind_in     = EvCfgEnter;
      row_in      = 3'd0;
      dir_in      = 2'sd0;
      code_in     = 4'd0;
      value_in    = 8'd0;
      unique case (head_desc.opcode) inside
         OpPage: begin
            if (head_desc.has_arg0) begin
               cfg_page_in = now_cfg;
               hit         = now_cfg || cfg_page_ff;
               kind_in     = now_cfg ? EvCfgEnter : EvCfgExit;
            end
         end
         OpNav: begin
            if (head_desc.has_arg0) begin
               if (head_desc.arg0 >= 8'd1 && head_desc.arg0 <= 8'd5) begin
                  hit     = 1'b1;
                  kind_in = head_desc.arg0[3:0] + 4'd1;
               end else if (head_desc.arg0 == NavCfgExit) begin
                  hit         = 1'b1;
                  cfg_page_in = 1'b0;
                  kind_in     = EvCfgExit;
               end
            end
         end
         OpRowAct, OpToggle, OpEdit: begin
            hit     = head_desc.has_arg0 && row_ok;
            row_in  = head_desc.arg0[2:0];
            kind_in = (head_desc.opcode == OpRowAct) ? EvRowAct :
                      (head_desc.opcode == OpToggle) ? EvToggle : EvEdit;
         end
         OpCycle: begin
            hit     = head_desc.has_arg1 && row_ok;
            row_in  = head_desc.arg0[2:0];
            kind_in = EvCycle;
            dir_in  = (head_desc.arg1 == 8'd0 || head_desc.arg1 == ByteAllOne) ?
                      -2'sd1 : 2'sd1;
         end
         OpHome: begin
            hit      = head_desc.has_arg1 && head_desc.arg0 >= 8'd1 &&
                       head_desc.arg0 <= 8'd15;
            kind_in  = EvCommand;
            code_in  = head_desc.arg0[3:0] - 4'd1;
            value_in = head_desc.arg1;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
      valid_in = valid_ff && !rsp_ready;
      if (pop && hit) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_id_ff  <= 8'd0;
         cfg_page_ff <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            page_id_ff <= csr_write_data;
         end
         if (pop) begin
            cfg_page_ff <= cfg_page_in;
         end
         valid_ff <= valid_in;
      end
      if (pop && hit) begin
         kind_ff  <= kind_in;
         row_ff   <= row_in;
         dir_ff   <= dir_in;
         code_ff  <= code_in;
         value_ff <= value_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_event_kind     = kind_ff;
   assign rsp_row_index      = row_ff;
   assign rsp_step_direction = dir_ff;
   assign rsp_command_code   = code_ff;
   assign rsp_command_value  = value_ff;

`ifndef SYNTHESIS
   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> kind_ff <= EvCommand)
      else $error("event kind out of range");
   a_dir_only_cycle: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff != EvCycle) |-> dir_ff == 2'sd0)
      else $error("step direction set on non-cycle event");
   a_enter_sets_page: assert property (@(posedge clock) disable iff (reset)
      (pop && hit && kind_in == EvCfgEnter) |=> cfg_page_ff)
      else $error("cfg enter without page flag");
`endif

endmodule

// ===== rtl/panel_event_frame_decoder.sv =====
// Frame decoder: one received byte per cycle, back to back, no stall on req_
// unless the two-entry frame queue is full.
// Path: the frame's last byte is written into the queue as it is taken; the queue head
// is then decoded into the rsp_ output register once that register is empty or read.
// Reset (synchronous, active high): framing, page flag, queue and rsp_valid clear;
// config_page_id returns to 0.
module panel_event_frame_decoder
   import pefd_pkg::*;
#(
   parameter int FRAME_BUF_SIZE = FrameBufSizeDefault,
   parameter int ROWS_PER_PAGE  = RowsPerPageDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [7:0]        csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [3:0]        rsp_event_kind,
   output logic [2:0]        rsp_row_index,
   output logic signed [1:0] rsp_step_direction,
   output logic [3:0]        rsp_command_code,
   output logic [7:0]        rsp_command_value
);

   logic           q_full;
   logic           q_push;
   logic           q_pop;
   logic           q_valid;
   frame_desc_type push_desc;
   frame_desc_type head_desc;

   pefd_front #(
      .FRAME_BUF_SIZE(FRAME_BUF_SIZE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_rx_byte(req_rx_byte),
      .queue_full (q_full),
      .push       (q_push),
      .push_desc  (push_desc)
   );

   pefd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .head_valid(q_valid),
      .head_desc (head_desc)
   );

   pefd_back #(
      .ROWS_PER_PAGE(ROWS_PER_PAGE)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .head_valid        (q_valid),
      .head_desc         (head_desc),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_row_index     (rsp_row_index),
      .rsp_step_direction(rsp_step_direction),
      .rsp_command_code  (rsp_command_code),
      .rsp_command_value (rsp_command_value)
   );

endmodule

// ===== dv/tb_panel_event_frame_decoder.sv =====
`timescale 1ns / 1ps

module tb_panel_event_frame_decoder;
   import pefd_pkg::*;

   localparam int BufSize        = FrameBufSizeDefault;
   localparam int RowsPerPage    = RowsPerPageDefault;
   localparam int HalfPeriod     = 6;
   localparam int DrainCycles    = 12;
   localparam int PhaseItems     = 230;
   localparam int NumPhases      = 5;

   localparam logic [7:0] NavHome     = 8'd1;
   localparam logic [7:0] NavPrev     = 8'd5;
   localparam logic [7:0] ActionFirst = 8'd1;
   localparam logic [7:0] ActionLast  = 8'd15;

   typedef struct packed {
      logic [3:0]        kind;
      logic [2:0]        row;
      logic signed [1:0] dir;
      logic [3:0]        code;
      logic [7:0]        value;
   } panel_event_type;

   typedef enum int {StallNone, StallRandom, StallSparse, StallLong} stall_mode_type;

   // tracks decoder state per accepted byte and holds the events still owed
   class panel_event_tracker;
      logic [7:0]      config_page_id;
      logic            in_frame;
      logic [7:0]      frame_length;
      int              bytes_taken;
      logic [7:0]      frame_store [FrameBufSizeDefault];
      logic            on_config_page;
      panel_event_type pending_events[$];
      int              mismatch_count;

      function new();
         config_page_id = '0;
         in_frame       = 1'b0;
         frame_length   = '0;
         bytes_taken    = 0;
         on_config_page = 1'b0;
         mismatch_count = 0;
      endfunction

      function automatic bit decode_frame(int len, output panel_event_type ev);
         int         plen;
         logic [7:0] op;
         logic [7:0] p0;
         logic [7:0] p1;
         logic       was;
         plen = len - 1;
         op   = frame_store[0];
         p0   = (plen >= 1) ? frame_store[1] : 8'h00;
         p1   = (plen >= 2) ? frame_store[2] : 8'h00;
         ev   = '0;
         case (op) inside
            OpPage: begin
               if (plen < 1) return 1'b0;
               was = on_config_page;
               on_config_page = (p0 == config_page_id);
               if (on_config_page) begin
                  ev.kind = EvCfgEnter;
                  return 1'b1;
               end
               if (was) begin
                  ev.kind = EvCfgExit;
                  return 1'b1;
               end
               return 1'b0;
            end
            OpNav: begin
               if (plen < 1) return 1'b0;
               if (p0 >= NavHome && p0 <= NavPrev) begin
                  ev.kind = EvHome + 4'(p0 - NavHome);
                  return 1'b1;
               end
               if (p0 == NavCfgExit) begin
                  on_config_page = 1'b0;
                  ev.kind = EvCfgExit;
                  return 1'b1;
               end
               return 1'b0;
            end
            OpRowAct, OpToggle, OpEdit: begin
               if (plen < 1 || p0 >= RowsPerPageDefault) return 1'b0;
               ev.kind = (op == OpRowAct) ? EvRowAct : ((op == OpToggle) ? EvToggle : EvEdit);
               ev.row  = p0[2:0];
               return 1'b1;
            end
            OpCycle: begin
               if (plen < 2 || p0 >= RowsPerPageDefault) return 1'b0;
               ev.kind = EvCycle;
               ev.row  = p0[2:0];
               ev.dir  = (p1 == 8'h00 || p1 == ByteAllOne) ? -2'sd1 : 2'sd1;
               return 1'b1;
            end
            OpHome: begin
               if (plen < 2) return 1'b0;
               if (p0 < ActionFirst || p0 > ActionLast) return 1'b0;
               ev.kind  = EvCommand;
               ev.code  = 4'(p0 - ActionFirst);
               ev.value = p1;
               return 1'b1;
            end
            default: return 1'b0;
         endcase
      endfunction

      function automatic void take_byte(logic [7:0] b);
         panel_event_type ev;
         int              len;
         if (!in_frame) begin
            if (b == FrameStart) begin
               in_frame     = 1'b1;
               frame_length = '0;
               bytes_taken  = 0;
            end
            return;
         end
         if (frame_length == 8'd0) begin
            if (b == 8'd0 || b > BufSize) begin
               in_frame = 1'b0;
            end else begin
               frame_length = b;
            end
            bytes_taken = 0;
            return;
         end
         if (bytes_taken < BufSize) frame_store[bytes_taken] = b;
         bytes_taken++;
         if (bytes_taken >= frame_length) begin
            len = frame_length;
            if (decode_frame(len, ev)) pending_events.push_back(ev);
            in_frame     = 1'b0;
            frame_length = '0;
            bytes_taken  = 0;
         end
      endfunction

      task report_mismatch(string what);
         mismatch_count++;
         $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      task match_event(panel_event_type got);
         panel_event_type want;
         if (pending_events.size() == 0) begin
            report_mismatch($sformatf("unexpected event kind %0d", got.kind));
            return;
         end
         want = pending_events.pop_front();
         if (got.kind !== want.kind)
            report_mismatch($sformatf("event_kind %0d, want %0d", got.kind, want.kind));
         if (got.row !== want.row)
            report_mismatch($sformatf("row_index %0d, want %0d", got.row, want.row));
         if (got.dir !== want.dir)
            report_mismatch($sformatf("step_direction %0d, want %0d", got.dir, want.dir));
         if (got.code !== want.code)
            report_mismatch($sformatf("command_code %0d, want %0d", got.code, want.code));
         if (got.value !== want.value)
            report_mismatch($sformatf("command_value %0d, want %0d", got.value, want.value));
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [7:0]        csr_write_data;
   logic              req_valid;
   logic              req_ready;
   logic [7:0]        req_rx_byte;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [3:0]        rsp_event_kind;
   logic [2:0]        rsp_row_index;
   logic signed [1:0] rsp_step_direction;
   logic [3:0]        rsp_command_code;
   logic [7:0]        rsp_command_value;

   panel_event_tracker tracker;
   panel_event_type    seen_event;
   logic [7:0]         frame_bytes[$];
   int                 burst_left;
   int                 items_sent;
   stall_mode_type     stall_mode;
   int                 mode_left;
   int                 stall_tick;

   panel_event_frame_decoder #(
      .FRAME_BUF_SIZE(BufSize),
      .ROWS_PER_PAGE (RowsPerPage)
   ) uut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_event_kind    (rsp_event_kind),
      .rsp_row_index     (rsp_row_index),
      .rsp_step_direction(rsp_step_direction),
      .rsp_command_code  (rsp_command_code),
      .rsp_command_value (rsp_command_value)
   );

   always #(HalfPeriod) clock = ~clock;

   // response side: check each transaction, then pick next ready level
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         seen_event.kind  = rsp_event_kind;
         seen_event.row   = rsp_row_index;
         seen_event.dir   = rsp_step_direction;
         seen_event.code  = rsp_command_code;
         seen_event.value = rsp_command_value;
         tracker.match_event(seen_event);
      end
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(100, 400);
      end
      mode_left--;
      stall_tick++;
      case (stall_mode)
         StallNone:   rsp_ready <= 1'b1;
         StallRandom: rsp_ready <= 1'($urandom_range(0, 1));
         StallSparse: rsp_ready <= (stall_tick % 5) == 0;
         default:     rsp_ready <= (stall_tick % 16) >= 10;
      endcase
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.take_byte(b);
   endtask

   task automatic send_queued();
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
      items_sent += frame_bytes.size();
      frame_bytes.delete();
   endtask

   task automatic send_random_frame();
      int         r;
      int         need;
      int         len;
      logic [7:0] op;
      logic [7:0] p0;
      logic [7:0] p1;
      r = $urandom_range(0, 99);
      if (r < 12) begin
         // line noise, mostly ignored outside a frame
         repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom()));
         send_queued();
         return;
      end
      frame_bytes.push_back(FrameStart);
      if (r < 18) begin
         case ($urandom_range(0, 2))
            0:       frame_bytes.push_back(8'd0);
            1:       frame_bytes.push_back(8'(BufSize + 1));
            default: frame_bytes.push_back(8'($urandom_range(BufSize + 1, 255)));
         endcase
         send_queued();
         return;
      end
      case ($urandom_range(0, 7))
         0:       op = OpPage;
         1:       op = OpNav;
         2:       op = OpRowAct;
         3:       op = OpToggle;
         4:       op = OpCycle;
         5:       op = OpEdit;
         6:       op = OpHome;
         default: op = 8'($urandom());
      endcase
      need = (op == OpCycle || op == OpHome) ? 2 : 1;
      r = $urandom_range(0, 9);
      if (r == 0)      len = $urandom_range(1, need);
      else if (r < 3)  len = $urandom_range(need + 1, BufSize);
      else             len = need + 1;
      case (op)
         OpPage:  p0 = ($urandom_range(0, 1) == 0) ? tracker.config_page_id : 8'($urandom());
         OpNav:   p0 = ($urandom_range(0, 5) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 7));
         OpHome:  p0 = ($urandom_range(0, 5) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 16));
         default: p0 = ($urandom_range(0, 6) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 9));
      endcase
      case ($urandom_range(0, 3))
         0:       p1 = 8'h00;
         1:       p1 = ByteAllOne;
         default: p1 = 8'($urandom());
      endcase
      frame_bytes.push_back(8'(len));
      frame_bytes.push_back(op);
      if (len >= 2) frame_bytes.push_back(p0);
      if (len >= 3) frame_bytes.push_back(p1);
      for (int i = 3; i < len; i++) frame_bytes.push_back(8'($urandom()));
      send_queued();
   endtask

   task automatic settle();
      // finish any open frame so the decoder is idle before a register write
      while (tracker.in_frame) begin
         if (tracker.frame_length == 8'd0) send_byte(8'd0);
         else send_byte(8'($urandom()));
      end
      req_valid <= 1'b0;
      while (tracker.pending_events.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_page_id(input logic [7:0] id);
      csr_write_enable <= 1'b1;
      csr_write_data   <= id;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.config_page_id = id;
   endtask

   initial begin
      #(2_000_000);
      $display("panel_event_frame_decoder verification failed");
      $finish;
   end

   initial begin
      logic [7:0] page_ids [NumPhases];
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = 8'h00;
      req_valid        = 1'b0;
      req_rx_byte      = 8'h00;
      rsp_ready        = 1'b0;
      burst_left       = 0;
      items_sent       = 0;
      stall_mode       = StallNone;
      mode_left        = 0;
      stall_tick       = 0;
      tracker          = new();
      page_ids = '{8'h00, 8'hFF, 8'($urandom()), 8'h01, 8'($urandom())};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int ph = 0; ph < NumPhases; ph++) begin
         write_page_id(page_ids[ph]);
         if (ph == 0) begin
            // enter config page, leave it by page change, leave by nav
            frame_bytes = '{FrameStart, 8'd2, OpPage, 8'h00};
            send_queued();
            frame_bytes = '{FrameStart, 8'd2, OpPage, 8'hFF};
            send_queued();
            frame_bytes = '{FrameStart, 8'd2, OpNav, NavCfgExit};
            send_queued();
            frame_bytes = '{FrameStart, 8'd3, OpCycle, 8'd7, ByteAllOne};
            send_queued();
            // '#' as a payload byte, top action code
            frame_bytes = '{FrameStart, 8'd3, OpHome, ActionLast, FrameStart};
            send_queued();
            frame_bytes = '{FrameStart, 8'd0};
            send_queued();
            // '#' as a length byte is above the buffer size
            frame_bytes = '{FrameStart, FrameStart};
            send_queued();
            frame_bytes = '{FrameStart, 8'd1, OpRowAct};
            send_queued();
         end
         items_sent = 0;
         while (items_sent < PhaseItems) send_random_frame();
         settle();
      end

      if (tracker.mismatch_count == 0 && tracker.pending_events.size() == 0) begin
         $display("panel_event_frame_decoder verification clean");
      end else begin
         $display("panel_event_frame_decoder verification failed");
      end
      $finish;
   end

endmodule
